// File: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must never be true outside reset
`define ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

// implication property, written by the caller with |-> or |=>
`define ASSERT_PROP(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

`endif

// File: rtl/vhmm_pkg.sv
package vhmm_pkg;

	localparam int BIN_COUNT  = 65536;
	localparam int COUNT_BITS = 32;
	localparam int BIN_BITS   = $clog2(BIN_COUNT);
	localparam int STEP_BITS  = $clog2(BIN_BITS);

	localparam logic [BIN_BITS-1:0] TOP_BIN = BIN_BITS'(BIN_COUNT - 1);

	localparam logic [31:0] MIN_RESET = 32'h7FFF_FFFF;
	localparam logic [31:0] MAX_RESET = 32'h8000_0000;

	// request codes
	localparam logic [1:0] REQ_ACC   = 2'd0;
	localparam logic [1:0] REQ_READ  = 2'd1;
	localparam logic [1:0] REQ_CLEAR = 2'd2;
	localparam logic [1:0] REQ_NONE  = 2'd3;

	// sample formats
	localparam logic [2:0] FMT_U8  = 3'd0;
	localparam logic [2:0] FMT_S8  = 3'd1;
	localparam logic [2:0] FMT_U16 = 3'd2;
	localparam logic [2:0] FMT_S16 = 3'd3;

	// configuration register indexes
	localparam logic [1:0] CFG_FORMAT = 2'd0;
	localparam logic [1:0] CFG_SMIN   = 2'd1;
	localparam logic [1:0] CFG_SMAX   = 2'd2;

	typedef struct packed {
		logic [1:0]  op;
		logic [15:0] bin;
		logic [31:0] ext_min;
		logic [31:0] ext_max;
	} item_t;

	typedef struct packed {
		logic [31:0] count;
		logic [15:0] bin;
		logic [31:0] ext_min;
		logic [31:0] ext_max;
	} result_t;

	typedef struct packed {
		logic sweeping;
	} back_status_t;

endpackage

// File: rtl/vhmm_front.sv
module vhmm_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic [1:0]           req_type,
	input  logic signed [31:0]   voxel_value,
	input  logic [15:0]          bin_index,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [1:0]           cfg_index,
	input  logic [31:0]          cfg_data,
	input  vhmm_pkg::back_status_t bstat,
	input  logic                 q_full,
	output logic                 q_push,
	output vhmm_pkg::item_t      q_item
);
	import vhmm_pkg::*;

	logic [2:0]  fmt_q;
	logic [31:0] smin_q, smax_q;
	logic [31:0] min_q, max_q;
	logic        busy_q, hold_v_q;
	item_t       hold_q;
	logic [STEP_BITS-1:0] step_q;
	logic [31:0] rem_q, den_q;
	logic [BIN_BITS-1:0] dlo_q, quo_q;

	logic        accept;
	logic [31:0] v;
	logic [16:0] dbin;
	logic [BIN_BITS-1:0] dbin_c, sbin;
	logic        scaled, need_div;
	logic signed [33:0] num, den, numa, dena;
	logic [31+BIN_BITS:0] dvd;
	logic [31:0] new_min, new_max;
	logic [32:0] rem33;
	logic        ge;

	assign cfg_ready = 1'b1;
	assign full      = busy_q | hold_v_q | bstat.sweeping;
	assign accept    = push & ~full;
	assign q_push    = hold_v_q & ~q_full;
	assign q_item    = hold_q;

	always_comb begin
		scaled = 1'b0;
		dbin   = '0;
		unique case (fmt_q)
			FMT_U8: begin
				v    = {24'd0, voxel_value[7:0]};
				dbin = {9'd0, voxel_value[7:0]};
			end
			FMT_S8: begin
				v    = {{24{voxel_value[7]}}, voxel_value[7:0]};
				dbin = {9'd0, ~voxel_value[7], voxel_value[6:0]};
			end
			FMT_U16: begin
				v    = {16'd0, voxel_value[15:0]};
				dbin = {1'b0, voxel_value[15:0]};
			end
			FMT_S16: begin
				v    = {{16{voxel_value[15]}}, voxel_value[15:0]};
				dbin = {1'b0, ~voxel_value[15], voxel_value[14:0]};
			end
			default: begin
				v      = voxel_value;
				scaled = 1'b1;
			end
		endcase
		dbin_c = (dbin > 17'(TOP_BIN)) ? TOP_BIN : dbin[BIN_BITS-1:0];

		num = 34'(signed'(v)) - 34'(signed'(smin_q));
		den = 34'(signed'(smax_q)) - 34'(signed'(smin_q));
		if (den < 0) begin
			numa = -num;
			dena = -den;
		end else begin
			numa = num;
			dena = den;
		end
		need_div = 1'b0;
		if (den == 0)
			sbin = (num < 0) ? '0 : TOP_BIN;
		else if (numa <= 0)
			sbin = '0;
		else if (numa >= dena)
			sbin = TOP_BIN;
		else begin
			sbin     = '0;
			need_div = 1'b1;
		end
		// numa * (BIN_COUNT-1) as shift and subtract
		dvd = {numa[31:0], {BIN_BITS{1'b0}}} - (32+BIN_BITS)'(numa[31:0]);

		new_min = ($signed(v) < $signed(min_q)) ? v : min_q;
		new_max = ($signed(v) > $signed(max_q)) ? v : max_q;

		rem33 = {rem_q, dlo_q[BIN_BITS-1]};
		ge    = rem33 >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q  <= FMT_U8;
			smin_q <= '0;
			smax_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_FORMAT: fmt_q  <= cfg_data[2:0];
				CFG_SMIN:   smin_q <= cfg_data;
				CFG_SMAX:   smax_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			hold_v_q <= 1'b0;
			min_q    <= MIN_RESET;
			max_q    <= MAX_RESET;
			step_q   <= '0;
		end else begin
			if (q_push)
				hold_v_q <= 1'b0;
			if (accept) begin
				unique case (req_type)
					REQ_ACC: begin
						min_q <= new_min;
						max_q <= new_max;
						if (scaled && need_div) begin
							busy_q <= 1'b1;
							step_q <= STEP_BITS'(BIN_BITS - 1);
						end else
							hold_v_q <= 1'b1;
					end
					REQ_CLEAR: begin
						min_q    <= MIN_RESET;
						max_q    <= MAX_RESET;
						hold_v_q <= 1'b1;
					end
					default: hold_v_q <= 1'b1;
				endcase
			end
			if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == '0) begin
					busy_q   <= 1'b0;
					hold_v_q <= 1'b1;
				end
			end
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (accept) begin
			hold_q.op <= req_type;
			unique case (req_type)
				REQ_ACC: begin
					hold_q.bin     <= 16'(scaled ? sbin : dbin_c);
					hold_q.ext_min <= new_min;
					hold_q.ext_max <= new_max;
				end
				REQ_READ: begin
					hold_q.bin     <= bin_index;
					hold_q.ext_min <= min_q;
					hold_q.ext_max <= max_q;
				end
				REQ_CLEAR: begin
					hold_q.bin     <= '0;
					hold_q.ext_min <= MIN_RESET;
					hold_q.ext_max <= MAX_RESET;
				end
				default: begin
					hold_q.bin     <= '0;
					hold_q.ext_min <= min_q;
					hold_q.ext_max <= max_q;
				end
			endcase
			rem_q <= dvd[31+BIN_BITS:BIN_BITS];
			dlo_q <= dvd[BIN_BITS-1:0];
			den_q <= dena[31:0];
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? 32'(rem33 - {1'b0, den_q}) : rem33[31:0];
			dlo_q <= {dlo_q[BIN_BITS-2:0], 1'b0};
			quo_q <= {quo_q[BIN_BITS-2:0], ge};
			if (step_q == '0)
				hold_q.bin <= 16'({quo_q[BIN_BITS-2:0], ge});
		end
	end

endmodule

// File: rtl/vhmm_queue.sv
module vhmm_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr,
	input  vhmm_pkg::item_t wr_item,
	output logic            q_full,
	input  logic            rd,
	output logic            q_empty,
	output vhmm_pkg::item_t rd_item
);
	import vhmm_pkg::*;

	item_t      ent_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign q_full  = cnt_q == 2'd2;
	assign q_empty = cnt_q == 2'd0;
	assign rd_item = ent_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (wr)
				wp_q <= ~wp_q;
			if (rd)
				rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(wr) - 2'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr)
			ent_q[wp_q] <= wr_item;
	end

endmodule

// File: rtl/vhmm_back.sv
module vhmm_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_empty,
	input  vhmm_pkg::item_t      q_item,
	output logic                 q_pop,
	input  logic                 pop,
	output logic                 empty,
	output vhmm_pkg::result_t    res,
	output vhmm_pkg::back_status_t bstat
);
	import vhmm_pkg::*;
	`include "assert_macros.svh"

	logic [COUNT_BITS-1:0] mem [BIN_COUNT];
	logic [COUNT_BITS-1:0] rdata_s1;
	logic                  sweep_q;
	logic [BIN_BITS-1:0]   sw_addr_q;
	logic                  s1_v_q;
	item_t                 s1_item;
	result_t               ent_q [2];
	logic                  wp_q, rp_q;
	logic [1:0]            ocnt_q;

	logic                  o_push, o_pop, mem_we, in_range;
	logic [BIN_BITS-1:0]   wa;
	logic [COUNT_BITS-1:0] wd, inc, cnt;
	logic [63:0]           cnt64;
	result_t               o_data;

	assign bstat.sweeping = sweep_q;
	assign q_pop = ~q_empty & ~sweep_q & ~s1_v_q & (ocnt_q != 2'd2);
	assign empty = ocnt_q == 2'd0;
	assign o_pop = pop & ~empty;
	assign res   = ent_q[rp_q];

	always_comb begin
		inc      = (rdata_s1 == '1) ? rdata_s1 : rdata_s1 + 1'b1;
		in_range = {1'b0, s1_item.bin} < 17'(BIN_COUNT);
		if (s1_item.op == REQ_ACC)
			cnt = inc;
		else
			cnt = in_range ? rdata_s1 : '0;
		cnt64 = 64'(cnt);

		o_push = 1'b0;
		o_data = '{count: '0, bin: q_item.bin, ext_min: q_item.ext_min,
			ext_max: q_item.ext_max};
		if (s1_v_q) begin
			o_push         = 1'b1;
			o_data.count   = (cnt64 > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : cnt64[31:0];
			o_data.bin     = s1_item.bin;
			o_data.ext_min = s1_item.ext_min;
			o_data.ext_max = s1_item.ext_max;
		end else if (q_pop && (q_item.op == REQ_CLEAR || q_item.op == REQ_NONE))
			o_push = 1'b1;

		mem_we = sweep_q | (s1_v_q & (s1_item.op == REQ_ACC));
		wa     = sweep_q ? sw_addr_q : s1_item.bin[BIN_BITS-1:0];
		wd     = sweep_q ? '0 : inc;
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[wa] <= wd;
		rdata_s1 <= mem[q_item.bin[BIN_BITS-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q   <= 1'b1;
			sw_addr_q <= '0;
			s1_v_q    <= 1'b0;
		end else begin
			s1_v_q <= q_pop & (q_item.op == REQ_ACC || q_item.op == REQ_READ);
			if (sweep_q) begin
				sw_addr_q <= sw_addr_q + 1'b1;
				if (sw_addr_q == TOP_BIN)
					sweep_q <= 1'b0;
			end else if (q_pop && q_item.op == REQ_CLEAR) begin
				sweep_q   <= 1'b1;
				sw_addr_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop)
			s1_item <= q_item;
	end

	// result queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= 1'b0;
			rp_q   <= 1'b0;
			ocnt_q <= '0;
		end else begin
			if (o_push)
				wp_q <= ~wp_q;
			if (o_pop)
				rp_q <= ~rp_q;
			ocnt_q <= ocnt_q + 2'(o_push) - 2'(o_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (o_push)
			ent_q[wp_q] <= o_data;
	end

	`ASSERT_NEVER(a_ocnt_range, ocnt_q == 2'd3, "result queue overfilled")
	`ASSERT_NEVER(a_pop_in_sweep, q_pop && sweep_q, "request taken during clearing pass")
	`ASSERT_PROP(a_s1_gap, s1_v_q |=> !s1_v_q, "memory stage issued back to back")
	`ASSERT_PROP(a_full_push, (ocnt_q == 2'd2 && !o_pop) |-> !o_push, "push into full result queue")

endmodule

// File: rtl/voxel_histogram_min_max_top.sv
// Accumulate/read requests go through the memory stage; a scaled voxel inside the range
// first runs the bit-serial bin divider; clear and unknown requests skip the memory stage.
// The back end takes no new request while a histogram read-modify-write is in flight,
// and the front end takes none while it holds a request or divides a scaled voxel.
// Reset: extremes and control registers are reset at once; a clearing pass over all 65536
// bins zeroes the counts (also after each clear request), full is high meanwhile.
module voxel_histogram_min_max_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [1:0]         req_type,
	input  logic signed [31:0] voxel_value,
	input  logic [15:0]        bin_index,
	output logic               empty,
	input  logic               pop,
	output logic [31:0]        bin_count,
	output logic [15:0]        bin_used,
	output logic signed [31:0] seen_min,
	output logic signed [31:0] seen_max,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data
);
	import vhmm_pkg::*;

	logic         q_push, q_full, q_pop, q_empty;
	item_t        f_item, b_item;
	result_t      res;
	back_status_t bstat;

	vhmm_front u_front (
		.clk, .arst_n, .push, .full, .req_type, .voxel_value, .bin_index,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .bstat,
		.q_full, .q_push, .q_item(f_item)
	);

	vhmm_queue u_queue (
		.clk, .arst_n, .wr(q_push), .wr_item(f_item), .q_full,
		.rd(q_pop), .q_empty, .rd_item(b_item)
	);

	vhmm_back u_back (
		.clk, .arst_n, .q_empty, .q_item(b_item), .q_pop,
		.pop, .empty, .res, .bstat
	);

	assign bin_count = res.count;
	assign bin_used  = res.bin;
	assign seen_min  = res.ext_min;
	assign seen_max  = res.ext_max;

endmodule
